[hw/rtl/pbmf_pkg.sv]
// Shared types, constants and the 32-bit population count for the PN matched filter.
`timescale 1ns / 1ps

package pbmf_pkg;

  localparam int COEF_REGS = 4;
  localparam int COEF_W    = 64;
  localparam int COEF_BITS = COEF_REGS * COEF_W;
  localparam int LEN_W     = 9;
  localparam int LEN_RESET = 256;
  localparam int SCORE_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CHUNK_W   = 32;
  localparam int CHUNK_CNT_W = 6;
  localparam int SUM_W     = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd4;

  localparam logic [31:0] M_PAIRS   = 32'h5555_5555;
  localparam logic [31:0] M_NIBBLES = 32'h3333_3333;
  localparam logic [31:0] M_BYTES   = 32'h0F0F_0F0F;
  localparam logic [31:0] M_HALVES  = 32'h00FF_00FF;
  localparam logic [31:0] M_WORD    = 32'h0000_FFFF;

  // Valid and end-of-word marker that travel with one chip position.
  typedef struct packed {
    logic valid;
    logic last;
  } pbmf_beat_t;

  // Tree population count of one 32-bit chunk.
  function automatic logic [CHUNK_CNT_W-1:0] popcount32(input logic [31:0] x);
    logic [31:0] r;
    r = (x & M_PAIRS) + ((x >> 1) & M_PAIRS);
    r = (r & M_NIBBLES) + ((r >> 2) & M_NIBBLES);
    r = (r & M_BYTES) + ((r >> 4) & M_BYTES);
    r = (r & M_HALVES) + ((r >> 8) & M_HALVES);
    r = (r & M_WORD) + ((r >> 16) & M_WORD);
    return r[CHUNK_CNT_W-1:0];
  endfunction

endpackage

[hw/rtl/pn_binary_matched_filter.sv]
// Top level of the binary PN-sequence matched filter.
`timescale 1ns / 1ps

// Binary PN matched filter on hard-decision chips.
// Input channel: in_valid, in_stall, in_chip_word. Each item is a word of
// WORD_BITS chips, oldest chip in the most significant bit. Result channel:
// out_valid, out_stall, out_score, out_last_of_word. Every input item yields
// WORD_BITS results, one per chip, and the last one carries out_last_of_word.
// Configuration port: cfg_valid, cfg_ready, cfg_index, cfg_data. Indexes 0 to 3
// load the 256 coefficient bits, index 4 loads the filter length; other
// indexes are ignored. cfg_ready is always high. Write only while idle.
// The word buffer takes each word; the history shifter moves one chip per
// cycle while the pipeline does not stall, and scores leave the result register
// one per cycle unless stalled. The next word is taken in the cycle the last
// chip of the current one is shifted, so words stream back to back with no
// gap in the results.
// Reset clears the chip history and the pipeline, sets all coefficients to
// zero and the length to 256 (or MAX_TAPS if smaller).
// When the receiver stalls, the result register holds and the two stages
// behind it fill up; the shifter stops and in_stall is high while chips wait.

module pn_binary_matched_filter
  import pbmf_pkg::*;
#(
  parameter int MAX_TAPS  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [WORD_BITS-1:0]      in_chip_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCORE_W-1:0] out_score,
  output logic                      out_last_of_word,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COEF_W-1:0]         cfg_data
);

  logic [MAX_TAPS-1:0] pattern;
  logic [MAX_TAPS-1:0] mask;
  logic [LEN_W-1:0]    length;
  logic [MAX_TAPS-1:0] history;
  pbmf_beat_t          beat;
  logic                corr_ready;

  // Register writes are never held off.
  assign cfg_ready = 1'b1;

  pbmf_cfg #(
    .MAX_TAPS(MAX_TAPS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .pattern  (pattern),
    .mask     (mask),
    .length   (length)
  );

  pbmf_shift #(
    .MAX_TAPS (MAX_TAPS),
    .WORD_BITS(WORD_BITS)
  ) u_shift (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_chip_word(in_chip_word),
    .next_ready  (corr_ready),
    .beat        (beat),
    .history     (history)
  );

  pbmf_corr #(
    .MAX_TAPS(MAX_TAPS)
  ) u_corr (
    .clk             (clk),
    .rst_n           (rst_n),
    .beat            (beat),
    .ready           (corr_ready),
    .history         (history),
    .pattern         (pattern),
    .mask            (mask),
    .length          (length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_score       (out_score),
    .out_last_of_word(out_last_of_word)
  );

endmodule

[hw/rtl/pbmf_cfg.sv]
// Configuration registers: coefficient pattern, effective length and compare mask.
`timescale 1ns / 1ps

module pbmf_cfg
  import pbmf_pkg::*;
#(
  parameter int MAX_TAPS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COEF_W-1:0]    wr_data,
  output logic [MAX_TAPS-1:0]  pattern,
  output logic [MAX_TAPS-1:0]  mask,
  output logic [LEN_W-1:0]     length
);

  localparam int LEN_RST_EFF = (MAX_TAPS < LEN_RESET) ? MAX_TAPS : LEN_RESET;
  localparam logic [MAX_TAPS-1:0] MASK_RST =
    {MAX_TAPS{1'b1}} >> (MAX_TAPS - LEN_RST_EFF);

  logic [COEF_W-1:0]   coef_r [COEF_REGS];
  logic [LEN_W-1:0]    len_r;
  logic [MAX_TAPS-1:0] mask_r;
  logic [LEN_W-1:0]    len_wr;
  logic [MAX_TAPS-1:0] mask_wr;

  // Lengths above the tap count saturate to the tap count.
  always_comb begin
    if (int'(wr_data[LEN_W-1:0]) > MAX_TAPS) begin
      len_wr = LEN_W'(MAX_TAPS);
    end else begin
      len_wr = wr_data[LEN_W-1:0];
    end
    for (int k = 0; k < MAX_TAPS; k++) begin
      mask_wr[k] = (k < int'(len_wr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COEF_REGS; i++) begin
        coef_r[i] <= '0;
      end
      len_r  <= LEN_W'(LEN_RST_EFF);
      mask_r <= MASK_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_COEF_0: coef_r[0] <= wr_data;
        CFG_COEF_1: coef_r[1] <= wr_data;
        CFG_COEF_2: coef_r[2] <= wr_data;
        CFG_COEF_3: coef_r[3] <= wr_data;
        CFG_LENGTH: begin
          len_r  <= len_wr;
          mask_r <= mask_wr;
        end
        default: ;
      endcase
    end
  end

  // Pattern bits beyond the coefficient registers read as zero.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_pat
    if (k < COEF_BITS) begin : g_reg
      assign pattern[k] = coef_r[k / COEF_W][k % COEF_W];
    end else begin : g_zero
      assign pattern[k] = 1'b0;
    end
  end

  assign mask   = mask_r;
  assign length = len_r;

endmodule

[hw/rtl/pbmf_shift.sv]
// Input word buffer and chip history shifter, one chip per cycle unless stalled.
`timescale 1ns / 1ps

module pbmf_shift
  import pbmf_pkg::*;
#(
  parameter int MAX_TAPS  = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] in_chip_word,
  input  logic                 next_ready,
  output pbmf_beat_t           beat,
  output logic [MAX_TAPS-1:0]  history
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] word_r;
  logic [CNT_W-1:0]     left_r;
  logic [MAX_TAPS-1:0]  hist_r;
  logic                 hv_r;
  logic                 last_r;
  logic                 shift;
  logic                 accept;

  // A snapshot in hist_r waits until the correlator takes it.
  assign shift    = (left_r != '0) && (!hv_r || next_ready);
  assign in_stall = !((left_r == '0) || ((left_r == CNT_W'(1)) && shift));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      hv_r   <= 1'b0;
      hist_r <= '0;
    end else begin
      if (accept) begin
        left_r <= CNT_W'(WORD_BITS);
      end else if (shift) begin
        left_r <= left_r - CNT_W'(1);
      end
      if (shift) begin
        hv_r   <= 1'b1;
        hist_r <= {hist_r[MAX_TAPS-2:0], word_r[WORD_BITS-1]};
      end else if (next_ready) begin
        hv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_chip_word;
    end else if (shift) begin
      word_r <= {word_r[WORD_BITS-2:0], 1'b0};
    end
    if (shift) begin
      last_r <= (left_r == CNT_W'(1));
    end
  end

  assign beat.valid = hv_r;
  assign beat.last  = last_r;
  assign history    = hist_r;

endmodule

[hw/rtl/pbmf_corr.sv]
// Two-stage correlator: chunk popcounts, then sum and score into the result register.
`timescale 1ns / 1ps

module pbmf_corr
  import pbmf_pkg::*;
#(
  parameter int MAX_TAPS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pbmf_beat_t                beat,
  output logic                      ready,
  input  logic [MAX_TAPS-1:0]       history,
  input  logic [MAX_TAPS-1:0]       pattern,
  input  logic [MAX_TAPS-1:0]       mask,
  input  logic [LEN_W-1:0]          length,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCORE_W-1:0] out_score,
  output logic                      out_last_of_word
);

  localparam int NCHUNK = (MAX_TAPS + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W  = NCHUNK * CHUNK_W;

  logic [PAD_W-1:0]       diff;
  logic [CHUNK_CNT_W-1:0] cnt_r [NCHUNK];
  logic                   av_r;
  logic                   alast_r;
  logic                   ov_r;
  logic                   olast_r;
  logic [SCORE_W-1:0]     score_r;
  logic                   out_ready;
  logic [SUM_W-1:0]       sum;
  logic [SCORE_W-1:0]     score_nxt;

  assign out_ready = !ov_r || !out_stall;
  assign ready     = !av_r || out_ready;
  assign diff      = PAD_W'((history ^ pattern) & mask);

  // The masked count never exceeds the length, so nine bits hold it.
  always_comb begin
    sum = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      sum = sum + SUM_W'(cnt_r[c]);
    end
    score_nxt = {sum[LEN_W-1:0], 1'b0} - {1'b0, length};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (ready) begin
        av_r <= beat.valid;
      end
      if (out_ready) begin
        ov_r <= av_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && beat.valid) begin
      alast_r <= beat.last;
      for (int c = 0; c < NCHUNK; c++) begin
        cnt_r[c] <= popcount32(diff[c*CHUNK_W +: CHUNK_W]);
      end
    end
    if (out_ready && av_r) begin
      olast_r <= alast_r;
      score_r <= score_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_score        = $signed(score_r);
  assign out_last_of_word = olast_r;

endmodule

[hw/rtl/pbmf_checker.sv]
// Port-level checker for the PN matched filter and its bind to the top level.
`timescale 1ns / 1ps

module pbmf_checker
  import pbmf_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [SCORE_W-1:0] out_score,
  input logic                      out_last_of_word
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score) && $stable(out_last_of_word))
    else $error("result changed while stalled");

  // An accepted word keeps the shifter busy, so the input stalls right after it.
  a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted right after the first");

  // Reset empties the pipeline and frees the input.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind pn_binary_matched_filter pbmf_checker u_pbmf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_score       (out_score),
  .out_last_of_word(out_last_of_word)
);

[test/tb_pn_binary_matched_filter.sv]
// Self-checking testbench for the binary PN matched filter: stimulus, predictor and checker.
`timescale 1ns / 1ps

module tb_pn_binary_matched_filter;
  import pbmf_pkg::*;

  localparam int TAPS           = COEF_BITS;
  localparam int WORD_W         = 32;
  localparam int WATCHDOG_LIMIT = 4000;

  // Register indexes past the length register. The block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // One step of the stimulus plan: a chip word, a register write, or a pause in
  // which the sender waits until every pending score has come back.
  typedef enum logic [1:0] {STEP_WORD, STEP_REG, STEP_DRAIN} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
  } plan_step_t;

  // One predicted score with its end-of-word marker.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               last;
  } score_beat_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic [WORD_W-1:0]         in_chip_word = '0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic signed [SCORE_W-1:0] out_score;
  logic                      out_last_of_word;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index    = '0;
  logic [COEF_W-1:0]         cfg_data     = '0;

  pn_binary_matched_filter #(
    .MAX_TAPS  (TAPS),
    .WORD_BITS (WORD_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_chip_word     (in_chip_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_score        (out_score),
    .out_last_of_word (out_last_of_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The plan that the initial block fills and the driver drains, and the scores
  // that the predictor has worked out but the block has not yet delivered.
  plan_step_t  word_plan[$];
  score_beat_t pending_scores[$];

  // The predictor's copy of the block: chip history, coefficients and length.
  logic [TAPS-1:0]      chip_history = '0;
  logic [COEF_BITS-1:0] live_coef    = '0;
  logic [LEN_W-1:0]     live_length  = LEN_W'(LEN_RESET);

  // Coefficients as they will stand once the plan so far has been applied. The
  // plan needs them to build chip runs that line up with the pattern.
  logic [COEF_BITS-1:0] plan_coef = '0;

  int words_accepted = 0;
  int scores_checked = 0;
  int reg_writes     = 0;
  int settings       = 0;
  int errors         = 0;
  int quiet_cycles   = 0;
  int drain_hold     = 0;

  logic next_in_valid;
  logic next_cfg_valid;
  logic calm;

  int len_choices [13] = '{0, 1, 31, 32, 33, 63, 64, 65, 128, 255, 256, 257, 511};

  // In this stretch neither side takes random breaks, so outside register writes and drains
  // the block runs at its full rate of one score per cycle with words back to back.
  assign calm = (words_accepted >= 90) && (words_accepted < 140);

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 30);
  endfunction

  // Applies one register write to a coefficient image. Writes to the length or
  // to a spare index leave the coefficients untouched.
  function automatic logic [COEF_BITS-1:0] merge_coef(input logic [COEF_BITS-1:0] old_bits,
                                                      input logic [CFG_IDX_W-1:0] idx,
                                                      input logic [COEF_W-1:0]    data);
    logic [COEF_BITS-1:0] merged;
    merged = old_bits;
    if (idx <= CFG_COEF_3) merged[idx*COEF_W +: COEF_W] = data;
    return merged;
  endfunction

  // Shifts the word's chips into the history, oldest first, and after each chip
  // predicts the score: twice the number of disagreeing bits among the newest
  // length chips, minus the length. Lengths above the tap count saturate.
  task automatic correlate_word(input logic [WORD_W-1:0] chips);
    int          used;
    int          miss;
    score_beat_t beat;
    used = (live_length > TAPS) ? TAPS : int'(live_length);
    for (int b = 0; b < WORD_W; b++) begin
      chip_history = {chip_history[TAPS-2:0], chips[WORD_W-1-b]};
      miss = $countones((chip_history ^ live_coef[TAPS-1:0]) & ~({TAPS{1'b1}} << used));
      beat.score = SCORE_W'(2 * miss - used);
      beat.last  = (b == WORD_W - 1);
      pending_scores.push_back(beat);
    end
  endtask

  task automatic note_fault(input string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Driver. It finishes the handshake in flight, updates the predictor with
  // whatever was accepted at this edge, and then starts the next plan step.
  // Register writes only go out once every pending score has arrived, so the
  // block is idle when its settings change.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_in_valid  = in_valid && in_stall;
      next_cfg_valid = cfg_valid && !cfg_ready;
      if (in_valid && !in_stall) begin
        correlate_word(in_chip_word);
        words_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        live_coef = merge_coef(live_coef, cfg_index, cfg_data);
        if (cfg_index == CFG_LENGTH) live_length = cfg_data[LEN_W-1:0];
        reg_writes++;
      end
      if (!next_in_valid && !next_cfg_valid && word_plan.size() > 0) begin
        if (drain_hold > 0) begin
          drain_hold--;
        end else begin
          case (word_plan[0].kind)
            STEP_WORD: begin
              if (!take_break()) begin
                in_chip_word   <= word_plan[0].data[WORD_W-1:0];
                next_in_valid  = 1'b1;
                void'(word_plan.pop_front());
              end
            end
            STEP_REG: begin
              if (pending_scores.size() == 0) begin
                cfg_index      <= word_plan[0].idx;
                cfg_data       <= word_plan[0].data;
                next_cfg_valid = 1'b1;
                void'(word_plan.pop_front());
              end
            end
            default: begin
              // The sender holds off until the result side has caught up, then
              // counts down a random drain hold before it resumes.
              if (pending_scores.size() == 0) begin
                drain_hold = $urandom_range(6, 1);
                void'(word_plan.pop_front());
              end
            end
          endcase
        end
      end
      in_valid  <= next_in_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // Monitor. Each accepted score is compared with the oldest prediction, and
  // the stall toward the block is chosen afresh every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_scores.size() == 0) begin
          note_fault($sformatf("unexpected score %0d last %0b", out_score, out_last_of_word));
        end else begin
          if (out_score !== pending_scores[0].score ||
              out_last_of_word !== pending_scores[0].last) begin
            note_fault($sformatf("score %0d: expected %0d last %0b, got %0d last %0b",
                                 scores_checked, $signed(pending_scores[0].score),
                                 pending_scores[0].last, out_score, out_last_of_word));
          end
          void'(pending_scores.pop_front());
        end
        scores_checked++;
      end
      out_stall <= take_break();
    end
  end

  // Watchdog. Any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_pn_binary_matched_filter: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic plan_word(input logic [WORD_W-1:0] chips);
    plan_step_t step;
    step.kind = STEP_WORD;
    step.idx  = '0;
    step.data = COEF_W'(chips);
    word_plan.push_back(step);
  endtask

  task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    plan_step_t step;
    step.kind = STEP_REG;
    step.idx  = idx;
    step.data = data;
    word_plan.push_back(step);
    plan_coef = merge_coef(plan_coef, idx, data);
  endtask

  task automatic plan_drain();
    plan_step_t step;
    step.kind = STEP_DRAIN;
    step.idx  = '0;
    step.data = '0;
    word_plan.push_back(step);
  endtask

  // Eight words that replay the coefficient pattern chip for chip, so that at
  // the end of the run the history equals the pattern (or its inverse). The
  // scores then reach the most negative or most positive value for the length.
  // Now and then a word gets one flipped chip, which can pull the score off the extreme.
  task automatic plan_pattern(input bit invert, input bit flip_one);
    logic [WORD_W-1:0] chips;
    for (int j = 0; j < TAPS / WORD_W; j++) begin
      chips = plan_coef[(TAPS / WORD_W - 1 - j) * WORD_W +: WORD_W];
      if (invert) chips = ~chips;
      if (flip_one && $urandom_range(3) == 0) chips[$urandom_range(WORD_W - 1)] ^= 1'b1;
      plan_word(chips);
    end
  endtask

  // A fresh setting: every coefficient register and the length are rewritten,
  // sometimes with a stray write to a spare index mixed in.
  task automatic plan_random_setting();
    logic [COEF_W-1:0] bits;
    for (int r = 0; r < COEF_REGS; r++) begin
      case ($urandom_range(9))
        0: bits = '0;
        1: bits = '1;
        default: bits = {$urandom, $urandom};
      endcase
      plan_reg(CFG_IDX_W'(r), bits);
    end
    if ($urandom_range(2) == 0) plan_reg(CFG_SPARE_6, {$urandom, $urandom});
    if ($urandom_range(1) == 0) begin
      plan_reg(CFG_LENGTH, COEF_W'(len_choices[$urandom_range(12)]));
    end else begin
      plan_reg(CFG_LENGTH, COEF_W'($urandom_range(511)));
    end
    settings++;
  endtask

  initial begin
    int n;
    int pick;

    // Directed part. Reset state first: zero pattern, full length of 256.
    plan_word(32'h0000_0000);
    plan_word(32'hFFFF_FFFF);
    plan_word(32'h8000_0000);
    settings++;

    // Zero length: nothing is compared and every score is zero.
    plan_reg(CFG_LENGTH, COEF_W'(0));
    plan_word($urandom);
    plan_word(32'hFFFF_FFFF);
    settings++;

    // A length above the tap count saturates; an all-ones pattern.
    plan_reg(CFG_COEF_0, '1);
    plan_reg(CFG_COEF_1, '1);
    plan_reg(CFG_COEF_2, '1);
    plan_reg(CFG_COEF_3, '1);
    plan_reg(CFG_LENGTH, COEF_W'(511));
    plan_word(32'hFFFF_FFFF);
    plan_word(32'h0000_0000);
    settings++;

    // Shortest nonzero length: only the newest chip counts.
    plan_reg(CFG_LENGTH, COEF_W'(1));
    plan_word(32'h0000_0001);
    plan_word(32'hFFFF_FFFE);
    settings++;

    // Length right at a coefficient register boundary.
    plan_reg(CFG_COEF_0, {$urandom, $urandom});
    plan_reg(CFG_LENGTH, COEF_W'(64));
    plan_word(32'h5555_5555);
    plan_word(32'hAAAA_AAAA);
    settings++;

    // Writes to spare indexes must change nothing; then full length against a
    // random pattern, fed the pattern itself.
    plan_reg(CFG_SPARE_5, '1);
    plan_reg(CFG_SPARE_6, {$urandom, $urandom});
    plan_reg(CFG_SPARE_7, '1);
    plan_reg(CFG_COEF_1, {$urandom, $urandom});
    plan_reg(CFG_COEF_2, {$urandom, $urandom});
    plan_reg(CFG_COEF_3, {$urandom, $urandom});
    plan_reg(CFG_LENGTH, COEF_W'(256));
    plan_pattern(1'b0, 1'b0);
    settings++;

    // Random part: seven settings of thirty words each. Words are random chips,
    // all-zero or all-ones words, or runs that replay the pattern and drive the
    // scores to their extremes. One setting may pause mid-stream until results drain.
    for (int phase = 0; phase < 7; phase++) begin
      plan_random_setting();
      n = 0;
      while (n < 30) begin
        if (phase == 3 && n >= 15 && n < 16) plan_drain();
        pick = $urandom_range(99);
        if (pick < 15 && n <= 22) begin
          plan_pattern(pick < 8, pick % 3 == 0);
          n += TAPS / WORD_W;
        end else if (pick < 22) begin
          plan_word((pick % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
          n++;
        end else begin
          plan_word($urandom);
          n++;
        end
      end
    end
    plan_drain();
    plan_word($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (word_plan.size() != 0 || in_valid || cfg_valid || pending_scores.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d scores from %0d chip words, with %0d register writes",
             scores_checked, words_accepted, reg_writes);
    $display("over %0d filter settings, lengths from zero past the tap count.", settings);
    if (errors == 0) begin
      $display("tb_pn_binary_matched_filter: PASS");
    end else begin
      $display("tb_pn_binary_matched_filter: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pbmf_pkg.sv
hw/rtl/pbmf_cfg.sv
hw/rtl/pbmf_shift.sv
hw/rtl/pbmf_corr.sv
hw/rtl/pn_binary_matched_filter.sv
hw/rtl/pbmf_checker.sv
test/tb_pn_binary_matched_filter.sv
